FILE: rtl/dfr_pkg.sv
`timescale 1ns / 1ps

package dfr_pkg;

   // Register indexes on the configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_CODE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MTU_LIMIT   = 8'd1;

   // Register reset values
   localparam logic [7:0]  ESCAPE_CODE_RESET = 8'd0;
   localparam logic [15:0] MTU_LIMIT_RESET   = 16'd1500;
   localparam logic [15:0] MTU_LIMIT_FLOOR   = 16'd2;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_COMPLETE  = 2'd1,
      KIND_DISCARD   = 2'd2,
      KIND_EMPTY     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] message_length;
      logic        last_result;
   } result_type;

   // Up to two results caused by one input item, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } pair_type;

endpackage

FILE: rtl/dfr_if.sv
`timescale 1ns / 1ps

// Received byte channel
interface dfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       packet_end;

   modport source (output valid, output rx_byte, output packet_end, input ready);
   modport sink   (input valid, input rx_byte, input packet_end, output ready);
endinterface

// Result channel
interface dfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] message_length;
   logic        last_result;

   modport source (output valid, output kind, output data_byte, output message_length,
                   output last_result, input ready);
   modport sink   (input valid, input kind, input data_byte, input message_length,
                   input last_result, output ready);
endinterface

// Configuration write channel
interface dfr_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dfr_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [15:0]                          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/dfr_step.sv
`timescale 1ns / 1ps

// Unstuffing decision for one byte: results and next deframer state
module dfr_step (
   input  logic              escape_pending,
   input  logic [15:0]       length_count,
   input  logic [7:0]        escape_code,
   input  logic [15:0]       mtu_limit,
   input  logic [7:0]        rx_byte,
   input  logic              packet_end,
   output dfr_pkg::pair_type pair,
   output logic              escape_pending_in,
   output logic [15:0]       length_count_in
);

   logic [15:0]          limit;
   logic                 match;
   logic [15:0]          data_base;
   logic [15:0]          data_len;
   logic                 discard;
   dfr_pkg::result_type  data_res;
   dfr_pkg::result_type  disc_res;
   dfr_pkg::result_type  delim_res;

   // Limits below two behave as two
   assign limit = (mtu_limit < dfr_pkg::MTU_LIMIT_FLOOR) ? dfr_pkg::MTU_LIMIT_FLOOR
                                                         : mtu_limit;
   assign match = (rx_byte == escape_code);

   // A delimiter ahead of the data byte restarts the count
   assign data_base = (escape_pending && !match) ? 16'd0 : length_count;
   assign data_len  = data_base + 16'd1;
   assign discard   = (data_len >= limit);

   // Candidate results
   always_comb begin
      data_res                = '0;
      data_res.kind           = dfr_pkg::KIND_DATA;
      data_res.data_byte      = rx_byte;

      disc_res                = '0;
      disc_res.kind           = dfr_pkg::KIND_DISCARD;

      delim_res               = '0;
      if (length_count != 16'd0) begin
         delim_res.kind           = dfr_pkg::KIND_COMPLETE;
         delim_res.message_length = length_count;
      end else begin
         delim_res.kind           = dfr_pkg::KIND_EMPTY;
      end
   end

   // Result selection and state update
   always_comb begin
      pair              = '0;
      escape_pending_in = 1'b0;
      length_count_in   = length_count;

      if (escape_pending || !match) begin
         // Data byte path, preceded by a delimiter after a lone escape
         if (escape_pending && !match) begin
            pair.first  = delim_res;
            pair.second = data_res;
            pair.second.last_result = 1'b1;
            pair.count  = 2'd2;
         end else if (discard) begin
            pair.first  = data_res;
            pair.second = disc_res;
            pair.second.last_result = 1'b1;
            pair.count  = 2'd2;
         end else begin
            pair.first  = data_res;
            pair.first.last_result = 1'b1;
            pair.count  = 2'd1;
         end
         length_count_in = discard ? 16'd0 : data_len;
      end else if (packet_end) begin
         // Escape closing a radio packet is a delimiter
         pair.first  = delim_res;
         pair.first.last_result = 1'b1;
         pair.count  = 2'd1;
         length_count_in = 16'd0;
      end else begin
         // Escape waits for the next byte
         escape_pending_in = 1'b1;
      end
   end

endmodule

FILE: rtl/dfr_out_buf.sv
`timescale 1ns / 1ps

// Two-entry result register, drains in order onto the result channel
module dfr_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dfr_pkg::pair_type pair,
   output logic              can_load,
   dfr_rsp_if.source         rsp
);

   logic                first_valid_ff,  first_valid_in;
   logic                second_valid_ff, second_valid_in;
   dfr_pkg::result_type first_ff;
   dfr_pkg::result_type second_ff;
   dfr_pkg::result_type head;
   logic                take;

   assign head = first_valid_ff ? first_ff : second_ff;
   assign take = rsp.valid && rsp.ready;

   // Free, or the last held item leaves this cycle
   assign can_load = !(first_valid_ff || second_valid_ff) ||
                     (take && !(first_valid_ff && second_valid_ff));

   assign rsp.valid          = first_valid_ff || second_valid_ff;
   assign rsp.kind           = head.kind;
   assign rsp.data_byte      = head.data_byte;
   assign rsp.message_length = head.message_length;
   assign rsp.last_result    = head.last_result;

   // Occupancy
   always_comb begin
      first_valid_in  = first_valid_ff;
      second_valid_in = second_valid_ff;
      if (load) begin
         first_valid_in  = 1'b1;
         second_valid_in = (pair.count == 2'd2);
      end else if (take) begin
         if (first_valid_ff) begin
            first_valid_in  = 1'b0;
         end else begin
            second_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_valid_ff  <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         first_valid_ff  <= first_valid_in;
         second_valid_ff <= second_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         first_ff  <= pair.first;
         second_ff <= pair.second;
      end
   end

endmodule

FILE: rtl/escape_unstuffing_deframer_core.sv
`timescale 1ns / 1ps
// The first result of a byte is offered once the byte has passed the input register and
// then the result register, which loads only when it can take the byte's results.
// Throughput: one byte per cycle with at most one result per byte and rsp_chan ready;
// a two-result byte holds the single result port, and so the input, until both leave.
// Reset clears escape state, message length and all valid flags; escape_code returns
// to 0 and mtu_limit to 1500.
module escape_unstuffing_deframer_core (
   input  logic      clock,
   input  logic      reset,
   dfr_req_if.sink   req_chan,
   dfr_rsp_if.source rsp_chan,
   dfr_csr_if.sink   csr_chan
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_end_ff;
   logic              pending_ff, pending_in;
   logic [15:0]       length_ff, length_in;
   logic [7:0]        escape_code_ff;
   logic [15:0]       mtu_limit_ff;
   dfr_pkg::pair_type pair;
   logic              can_load;
   logic              advance;
   logic              load;
   logic              req_take;

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_code_ff <= dfr_pkg::ESCAPE_CODE_RESET;
         mtu_limit_ff   <= dfr_pkg::MTU_LIMIT_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == dfr_pkg::CSR_ESCAPE_CODE) begin
            escape_code_ff <= csr_chan.data[7:0];
         end else if (csr_chan.index == dfr_pkg::CSR_MTU_LIMIT) begin
            mtu_limit_ff   <= csr_chan.data;
         end
      end
   end

   // Input register handshake
   assign advance        = in_valid_ff && ((pair.count == 2'd0) || can_load);
   assign load           = advance && (pair.count != 2'd0);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
         in_end_ff  <= req_chan.packet_end;
      end
   end

   // Unstuffing logic
   dfr_step u_step (
      .escape_pending    (pending_ff),
      .length_count      (length_ff),
      .escape_code       (escape_code_ff),
      .mtu_limit         (mtu_limit_ff),
      .rx_byte           (in_byte_ff),
      .packet_end        (in_end_ff),
      .pair              (pair),
      .escape_pending_in (pending_in),
      .length_count_in   (length_in)
   );

   // Deframer state commits when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         length_ff  <= 16'd0;
      end else if (advance) begin
         pending_ff <= pending_in;
         length_ff  <= length_in;
      end
   end

   // Result register
   dfr_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .pair     (pair),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

endmodule

FILE: verif/tb_escape_unstuffing_deframer_core.sv
`timescale 1ns / 1ps

module tb_escape_unstuffing_deframer_core;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLDOFF_LEN   = 300;

   logic clock;
   logic reset;

   dfr_req_if req_bus ();
   dfr_rsp_if rsp_bus ();
   dfr_csr_if csr_bus ();

   escape_unstuffing_deframer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predicted deframer state and register copies
   logic [7:0]  pred_escape;
   logic [15:0] pred_mtu;
   logic        pred_esc_pending;
   logic [15:0] pred_msg_len;

   // Results still owed by the block, oldest first
   dfr_pkg::result_type unstuffed_expect_q[$];

   bit tx_idle_on;
   bit rx_idle_on;
   int rsp_hold_req;
   int rsp_hold_cnt;
   int rsp_stall_cnt;
   int cycle_count;
   int bytes_sent;
   int results_seen;
   int mismatch_count;
   int kind_seen[4];

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                  unstuffed_expect_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic dfr_pkg::result_type make_result(dfr_pkg::kind_type k, logic [7:0] b,
                                                       logic [15:0] len);
      dfr_pkg::result_type r;
      r.kind           = k;
      r.data_byte      = b;
      r.message_length = len;
      r.last_result    = 1'b0;
      return r;
   endfunction

   // Unstuff one received byte and queue the results it should cause
   function automatic void unstuff_predict(logic [7:0] rx, logic pe);
      dfr_pkg::result_type step_q[$];
      dfr_pkg::result_type r;
      logic [15:0]         lim;
      bit                  is_data;
      bit                  is_delim;
      lim      = (pred_mtu < dfr_pkg::MTU_LIMIT_FLOOR) ? dfr_pkg::MTU_LIMIT_FLOOR : pred_mtu;
      is_data  = 1'b0;
      is_delim = 1'b0;
      if (pred_esc_pending) begin
         pred_esc_pending = 1'b0;
         is_data  = 1'b1;
         is_delim = (rx != pred_escape);
      end else if (rx == pred_escape) begin
         if (pe) is_delim = 1'b1;
         else pred_esc_pending = 1'b1;
      end else begin
         is_data = 1'b1;
      end
      // delimiter closes the message before the byte that follows it
      if (is_delim) begin
         if (pred_msg_len != 16'd0)
            step_q = {step_q, make_result(dfr_pkg::KIND_COMPLETE, 8'd0, pred_msg_len)};
         else
            step_q = {step_q, make_result(dfr_pkg::KIND_EMPTY, 8'd0, 16'd0)};
         pred_msg_len = 16'd0;
      end
      if (is_data) begin
         step_q = {step_q, make_result(dfr_pkg::KIND_DATA, rx, 16'd0)};
         pred_msg_len = pred_msg_len + 16'd1;
         if (pred_msg_len >= lim) begin
            step_q = {step_q, make_result(dfr_pkg::KIND_DISCARD, 8'd0, 16'd0)};
            pred_msg_len = 16'd0;
         end
      end
      foreach (step_q[i]) begin
         r = step_q[i];
         r.last_result = (i == step_q.size() - 1);
         unstuffed_expect_q = {unstuffed_expect_q, r};
      end
   endfunction

   // Result receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_cnt = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (rsp_hold_cnt > 0) begin
         rsp_hold_cnt--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_cnt > 0) begin
         rsp_stall_cnt--;
         rsp_bus.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 10) begin
         rsp_stall_cnt = $urandom_range(1, 16) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin : check_results
      dfr_pkg::result_type exp_r;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         kind_seen[rsp_bus.kind]++;
         if (unstuffed_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] unexpected result: kind %0d byte %02h len %0d last %0b",
                        $realtime, rsp_bus.kind, rsp_bus.data_byte,
                        rsp_bus.message_length, rsp_bus.last_result);
         end else begin
            exp_r = unstuffed_expect_q[0];
            unstuffed_expect_q.delete(0);
            if (rsp_bus.kind !== exp_r.kind || rsp_bus.data_byte !== exp_r.data_byte ||
                rsp_bus.message_length !== exp_r.message_length ||
                rsp_bus.last_result !== exp_r.last_result) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"[%0t] mismatch: expected kind %0d byte %02h len %0d last %0b, ",
                            "got kind %0d byte %02h len %0d last %0b"}, $realtime,
                           exp_r.kind, exp_r.data_byte, exp_r.message_length,
                           exp_r.last_result, rsp_bus.kind, rsp_bus.data_byte,
                           rsp_bus.message_length, rsp_bus.last_result);
            end
         end
      end
   end

   // Offer one item, with an optional gap first; valid stays high on return
   task automatic send_byte(logic [7:0] rx, logic pe);
      int gap;
      if (tx_idle_on && $urandom_range(0, 99) < 12) begin
         gap = $urandom_range(1, 16);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.rx_byte    <= rx;
      req_bus.packet_end <= pe;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      unstuff_predict(rx, pe);
      bytes_sent++;
   endtask

   // Stop offering, wait for every owed result, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (unstuffed_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [dfr_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      // unknown indexes are dropped by the block
      if (idx == dfr_pkg::CSR_ESCAPE_CODE) pred_escape = value[7:0];
      else if (idx == dfr_pkg::CSR_MTU_LIMIT) pred_mtu = value;
   endtask

   task automatic configure(logic [7:0] esc, logic [15:0] mtu);
      logic [7:0] upper;
      upper = 8'($urandom);
      settle();
      write_reg(dfr_pkg::CSR_ESCAPE_CODE, {upper, esc});
      write_reg(dfr_pkg::CSR_MTU_LIMIT, mtu);
   endtask

   // Stuffed messages with random content, mixed with loose noise bytes
   task automatic send_message_traffic(int n);
      int          start;
      int          len;
      int          max_len;
      logic [15:0] eff_mtu;
      logic [7:0]  b;
      start   = bytes_sent;
      eff_mtu = (pred_mtu < dfr_pkg::MTU_LIMIT_FLOOR) ? dfr_pkg::MTU_LIMIT_FLOOR : pred_mtu;
      max_len = (eff_mtu < 16'd40) ? int'(eff_mtu) + 3 : 24;
      while (bytes_sent - start < n) begin
         if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(0, max_len);
            repeat (len) begin
               b = ($urandom_range(0, 4) == 0) ? pred_escape : 8'($urandom);
               if (b == pred_escape) begin
                  send_byte(b, 1'b0);
                  send_byte(b, $urandom_range(0, 7) == 0);
               end else begin
                  send_byte(b, $urandom_range(0, 15) == 0);
               end
            end
            // closing delimiter: at packet end, or resolved by the next byte
            send_byte(pred_escape, $urandom_range(0, 1) == 1);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               b = ($urandom_range(0, 2) == 0) ? pred_escape : 8'($urandom);
               send_byte(b, $urandom_range(0, 3) == 0);
            end
         end
      end
   endtask

   // Reset values: escape 0, limit 1500
   task automatic test_reset_defaults();
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();
   endtask

   // Field extremes and every escape combination
   task automatic test_directed_cases();
      configure(8'h7E, 16'd1500);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7E, 1'b1);   // delimiter at packet end, two bytes
      send_byte(8'h7E, 1'b1);   // empty delimiter
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7E, 1'b1);   // literal escape even at packet end
      send_byte(8'h7E, 1'b0);
      send_byte(8'h55, 1'b0);   // complete plus data
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7E, 1'b0);   // literal escape
      send_byte(8'h7E, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h7E, 1'b1);
      send_byte(8'h7E, 1'b0);
      send_byte(8'hAA, 1'b0);   // empty delimiter plus data
      send_byte(8'h7E, 1'b1);
      settle();
   endtask

   // Limits below the floor act as two
   task automatic test_mtu_floor();
      configure(8'h7E, 16'd0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h11, 1'b1);
      configure(8'h7E, 16'd1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h13, 1'b0);
      configure(8'h7E, 16'd2);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h21, 1'b1);
      settle();
   endtask

   // Escape code changed while an escape is pending
   task automatic test_pending_change();
      configure(8'h7E, 16'd1500);
      send_byte(8'h7E, 1'b0);
      configure(8'h33, 16'd1500);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h33, 1'b0);
      configure(8'h7E, 16'd1500);
      send_byte(8'h33, 1'b0);
      send_byte(8'h7E, 1'b1);
      settle();
   endtask

   // Writes to unknown indexes change nothing
   task automatic test_bad_index();
      configure(8'h5A, 16'd4);
      write_reg(8'd2, 16'hFFFF);
      write_reg(8'hFF, 16'h0000);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h5A, 1'b1);
      settle();
   endtask

   // Receiver stops for a long stretch while the sender keeps offering
   task automatic test_receiver_holdoff();
      configure(8'h7E, 16'd8);
      tx_idle_on   = 1'b0;
      rsp_hold_req = HOLDOFF_LEN;
      send_message_traffic(60);
      tx_idle_on = 1'b1;
      settle();
   endtask

   // Random traffic over several register settings
   task automatic test_random_phases();
      logic [7:0]  esc_list[8];
      logic [15:0] mtu_list[8];
      esc_list = '{8'h7E, 8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'hDB, 8'($urandom)};
      mtu_list = '{16'd1500, 16'd3, 16'd2, 16'd0, 16'd1, 16'($urandom_range(3, 40)),
                   16'hFFFF, 16'($urandom)};
      foreach (esc_list[i]) begin
         configure(esc_list[i], mtu_list[i]);
         send_message_traffic(50);
         // sender waits for the block to drain mid-phase
         settle();
         send_message_traffic(50);
      end
      settle();
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_final_no_idle();
      configure(8'($urandom), 16'($urandom_range(2, 20)));
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_message_traffic(100);
      settle();
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= 8'd0;
      req_bus.packet_end <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= dfr_pkg::CSR_ESCAPE_CODE;
      csr_bus.data      <= 16'd0;
      pred_escape      = dfr_pkg::ESCAPE_CODE_RESET;
      pred_mtu         = dfr_pkg::MTU_LIMIT_RESET;
      pred_esc_pending = 1'b0;
      pred_msg_len     = 16'd0;
      tx_idle_on       = 1'b1;
      rx_idle_on       = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_cases();
      test_mtu_floor();
      test_pending_change();
      test_bad_index();
      test_receiver_holdoff();
      test_random_phases();
      test_final_no_idle();

      $display("Sent %0d bytes, checked %0d results: %0d data, %0d complete, %0d discard, %0d empty",
               bytes_sent, results_seen, kind_seen[dfr_pkg::KIND_DATA],
               kind_seen[dfr_pkg::KIND_COMPLETE], kind_seen[dfr_pkg::KIND_DISCARD],
               kind_seen[dfr_pkg::KIND_EMPTY]);
      $display("Escape codes 00/FF/random, limits 0..65535, holdoff and stalls; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && unstuffed_expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dfr_pkg.sv
rtl/dfr_if.sv
rtl/dfr_step.sv
rtl/dfr_out_buf.sv
rtl/escape_unstuffing_deframer_core.sv
verif/tb_escape_unstuffing_deframer_core.sv
